// File: design/rsn_pkg.sv
// Shared types and widths for the ray/sphere nearest-hit pipeline.
`timescale 1ns / 1ps
package rsn_pkg;

  localparam int HW = 37;   // h, Q.16 signed
  localparam int CW = 67;   // c, Q.32 signed
  localparam int DW = 74;   // disc, Q.32 signed
  localparam int RW = 73;   // sqrt remainder, unsigned
  localparam int SW = 38;   // sqrt root bits
  localparam int TRW = 78;  // trial subtrahend width

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } hit_t;

  // one beat moving through the square-root stages
  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic signed [HW-1:0] h;
    logic [2:0][31:0]     org;
    logic [2:0][31:0]     dir;
    logic [RW-1:0]        rem;
    logic [SW-1:0]        root;
  } sq_t;

endpackage

// File: design/rsn_front.sv
// Front stages: difference, dot products, h, c and the discriminant.
`timescale 1ns / 1ps
module rsn_front
  import rsn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  ray_t req,
  output sq_t  q
);

  // stage 1
  logic                     v1;
  logic signed [2:0][31:0]  org1, dir1;
  logic signed [32:0]       diff1 [3];
  logic [30:0]              r1;
  // stage 2
  logic                     v2;
  logic [2:0][31:0]         org2, dir2;
  logic signed [64:0]       hp2 [3];
  logic signed [65:0]       cp2 [3];
  logic [61:0]              rr2;
  // stage 3
  logic                     v3;
  logic [2:0][31:0]         org3, dir3;
  logic signed [HW-1:0]     h3;
  logic signed [CW-1:0]     c3;
  // stage 4
  logic                     v4;
  logic [2:0][31:0]         org4, dir4;
  logic signed [HW-1:0]     h4;
  logic signed [CW-1:0]     c4;
  logic signed [35:0]       hisq4;
  logic signed [37:0]       hilo4;
  logic [37:0]              losq4;

  logic signed [66:0]       hsum;
  logic signed [67:0]       csum;
  logic signed [DW-1:0]     disc;
  logic signed [17:0]       hhi;
  logic signed [19:0]       hlo;

  assign hsum = 67'(hp2[0]) + 67'(hp2[1]) + 67'(hp2[2]);
  assign csum = 68'(cp2[0]) + 68'(cp2[1]) + 68'(cp2[2]) - $signed({6'b0, rr2});
  assign hhi  = h3[HW-1:19];
  assign hlo  = $signed({1'b0, h3[18:0]});
  assign disc = (DW'(hisq4) <<< 38) + (DW'(hilo4) <<< 20) + $signed({36'b0, losq4})
                - DW'(c4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      q.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      q.valid <= v4;
    end

    org1 <= {req.origin_z, req.origin_y, req.origin_x};
    dir1 <= {req.dir_z, req.dir_y, req.dir_x};
    diff1[0] <= 33'(req.origin_x) - 33'(req.center_x);
    diff1[1] <= 33'(req.origin_y) - 33'(req.center_y);
    diff1[2] <= 33'(req.origin_z) - 33'(req.center_z);
    r1 <= req.radius;

    org2 <= org1;
    dir2 <= dir1;
    for (int i = 0; i < 3; i++) begin
      hp2[i] <= 65'(diff1[i]) * 65'($signed(dir1[i]));
      cp2[i] <= 66'(diff1[i]) * 66'(diff1[i]);
    end
    rr2 <= 62'(r1) * 62'(r1);

    org3 <= org2;
    dir3 <= dir2;
    h3   <= hsum[66:30];
    c3   <= csum[CW-1:0];

    org4  <= org3;
    dir4  <= dir3;
    h4    <= h3;
    c4    <= c3;
    hisq4 <= 36'(hhi) * 36'(hhi);
    hilo4 <= 38'(hhi) * 38'(hlo);
    losq4 <= 38'(h3[18:0]) * 38'(h3[18:0]);

    q.org  <= org4;
    q.dir  <= dir4;
    q.h    <= h4;
    q.miss <= disc[DW-1];
    q.rem  <= disc[DW-1] ? '0 : disc[RW-1:0];
    q.root <= '0;
  end

endmodule

// File: design/rsn_sqrt_stage.sv
// One bit of the restoring integer square root.
`timescale 1ns / 1ps
module rsn_sqrt_stage
  import rsn_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  sq_t  d,
  output sq_t  q
);

  logic [TRW-1:0] trial;
  logic [TRW-1:0] rem_ext;
  logic           take;

  // (2*s + 2^BIT) * 2^BIT; low bits of s are still zero here
  assign trial   = (TRW'(d.root) << (BIT + 1)) | (TRW'(1) << (2 * BIT));
  assign rem_ext = TRW'(d.rem);
  assign take    = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.miss <= d.miss;
    q.h    <= d.h;
    q.org  <= d.org;
    q.dir  <= d.dir;
    q.rem  <= take ? RW'(rem_ext - trial) : d.rem;
    q.root <= take ? (d.root | (SW'(1) << BIT)) : d.root;
  end

endmodule

// File: design/rsn_back.sv
// Back stages: root choice, point = origin + dir * t, saturation.
`timescale 1ns / 1ps
module rsn_back
  import rsn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sq_t  d,
  output logic done,
  output hit_t rsp
);

  logic signed [39:0] hx, sx, t1, t2;
  logic               sel_hit;
  logic [SW-1:0]      tsel;

  logic               va, hita;
  logic [2:0][31:0]   orga, dira;
  logic [SW-1:0]      ta;

  logic               vb, hitb;
  logic [2:0][31:0]   orgb;
  logic signed [51:0] phi [3];
  logic signed [51:0] plo [3];

  logic signed [70:0] prod [3];
  logic signed [41:0] sum  [3];
  logic signed [31:0] pt   [3];

  assign hx = 40'(d.h);
  assign sx = $signed({2'b0, d.root});
  assign t1 = sx - hx;
  assign t2 = -hx - sx;

  always_comb begin
    sel_hit = 1'b1;
    tsel    = t2[SW-1:0];
    if (t2[39]) begin
      tsel = t1[SW-1:0];
      if (t1[39]) sel_hit = 1'b0;
    end
    if (d.miss) sel_hit = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (71'(phi[i]) <<< 19) + 71'(plo[i]);
      sum[i]  = 42'($signed(orgb[i])) + 42'($signed(prod[i][70:30]));
      if (sum[i] > 42'sd2147483647)       pt[i] = 32'sh7fffffff;
      else if (sum[i] < -42'sd2147483648) pt[i] = 32'sh80000000;
      else                                pt[i] = sum[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= d.valid;
      vb   <= va;
      done <= vb;
    end

    hita <= sel_hit;
    orga <= d.org;
    dira <= d.dir;
    ta   <= tsel;

    hitb <= hita;
    orgb <= orga;
    for (int i = 0; i < 3; i++) begin
      phi[i] <= 52'($signed(dira[i])) * $signed({33'b0, ta[SW-1:19]});
      plo[i] <= 52'($signed(dira[i])) * $signed({33'b0, ta[18:0]});
    end

    rsp.hit     <= hitb;
    rsp.point_x <= hitb ? pt[0] : '0;
    rsp.point_y <= hitb ? pt[1] : '0;
    rsp.point_z <= hitb ? pt[2] : '0;
  end

endmodule

// File: design/ray_sphere_nearest_hit.sv
// Top level: ray/sphere nearest-hit pipeline.
//
// Command channel: a ray/sphere pair on req is taken at each rising edge
// with start high and busy low. busy is always low: the pipeline takes a
// new beat every cycle.
// Result channel: done pulses for one cycle with the result on rsp
// (hit flag and hit point, zero point on a miss).
// Stages from the accepting edge to the done cycle: 5 front
// stages (difference, products, h/c, h squared split into partial
// products, discriminant), 38 square-root stages at one root bit each,
// and 3 back stages (root choice, split multiply, sum and saturate).
// Throughput: one beat per cycle, set by the one-bit-per-stage root.
// Reset clears only the valid bits; beats in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module ray_sphere_nearest_hit
  import rsn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ray_t req,
  output logic done,
  output hit_t rsp
);

  sq_t chain [SW+1];

  assign busy = 1'b0;

  rsn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .q     (chain[0])
  );

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    rsn_sqrt_stage #(.BIT(SW - 1 - g)) u_stage (
      .clk (clk),
      .rst (rst),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  rsn_back u_back (
    .clk  (clk),
    .rst  (rst),
    .d    (chain[SW]),
    .done (done),
    .rsp  (rsp)
  );

endmodule
